@@ src/aesm_pkg.sv @@
// ----------------------------------------------------------------------------
// aesm_pkg
// Shared types, constants and round functions for the AES block cipher core.
// ----------------------------------------------------------------------------
package aesm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_START,
    ST_ARK0,
    ST_ROUND,
    ST_FIN
  } aesm_state_t;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_IV_HI  = 3'd4,
    REG_IV_LO  = 3'd5,
    REG_KSIZE  = 3'd6,
    REG_MODE   = 3'd7
  } aesm_reg_t;

  typedef enum logic [1:0] {
    KIND_ECB = 2'd0,
    KIND_CBC = 2'd1,
    KIND_CFB = 2'd2,
    KIND_OFB = 2'd3
  } aesm_kind_t;

  localparam logic [1:0] KSIZE_128 = 2'd0;
  localparam logic [1:0] KSIZE_192 = 2'd1;
  localparam int unsigned KEY_ROWS = 15;

  localparam logic [7:0] SBOX_TBL [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX_TBL [0:255] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX_TBL[w[31:24]], SBOX_TBL[w[23:16]],
                SBOX_TBL[w[15:8]], SBOX_TBL[w[7:0]]};
  endfunction

  // byte k of a block sits at [127-8k -: 8]
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int k = 0; k < 16; k++) begin
      t[127-8*k -: 8] = inv ? INV_SBOX_TBL[s[127-8*k -: 8]] : SBOX_TBL[s[127-8*k -: 8]];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? 4 * ((c - r + 4) % 4) + r : 4 * ((c + r) % 4) + r;
        t[127-8*(4*c+r) -: 8] = s[127-8*src -: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m0 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = s[127-8*(4*c+k) -: 8];
        x2[k] = xt(a[k]);
        x4[k] = xt(x2[k]);
        x8[k] = xt(x4[k]);
        // coefficient sets: 2,3,1,1 forward and e,b,d,9 inverse
        m0[k] = inv ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
        m1[k] = inv ? (x8[k] ^ x2[k] ^ a[k]) : (x2[k] ^ a[k]);
        m2[k] = inv ? (x8[k] ^ x4[k] ^ a[k]) : a[k];
        m3[k] = inv ? (x8[k] ^ a[k]) : a[k];
      end
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = m0[r] ^ m1[(r+1)%4] ^ m2[(r+2)%4] ^ m3[(r+3)%4];
      end
    end
    mix_columns = t;
  endfunction

endpackage

@@ src/aesm_ram.sv @@
// ----------------------------------------------------------------------------
// aesm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aesm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/aes_block_cipher_with_modes_core.sv @@
// ----------------------------------------------------------------------------
// aes_block_cipher_with_modes_core
// AES-128/192/256 with ECB, CBC, CFB and OFB chaining; round keys in a RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_ready | in_block_high, in_block_low, in_first_block
//  out     | output    | out_valid/out_ready | out_result_high, out_result_low
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
//  Rounds run one per cycle, paced by the single read port of the round
//  key RAM (one 128-bit row per round).
//  After a key or key size write the next block first runs the key
//  expansion, one word per cycle.
//  Reset is synchronous; the round key RAM is not cleared.
//  A stalled result holds in the output register; the next transaction is
//  accepted meanwhile and finishes once the output register is free.
// ----------------------------------------------------------------------------
module aes_block_cipher_with_modes_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_first_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aesm_pkg::*;

  localparam int KA_W = $clog2(KEY_ROWS);

  aesm_state_t state_r, state_nxt;

  logic [63:0]   key_word_r [4];
  logic [63:0]   iv_high_r, iv_low_r;
  logic [1:0]    key_size_r;
  logic [2:0]    cipher_mode_r;
  logic          sched_ready_r, sched_ready_nxt;
  logic [127:0]  chain_r, chain_nxt;
  logic [127:0]  data_r, data_nxt;
  logic [127:0]  st_r, st_nxt;
  logic [KA_W-1:0] ka_r, ka_nxt;
  logic [3:0]    rnd_r, rnd_nxt;
  logic [5:0]    i_r, i_nxt;
  logic [2:0]    pos_r, pos_nxt;
  logic [7:0]    rcon_r, rcon_nxt;
  logic [31:0]   win_r [8];
  logic [31:0]   win_nxt [8];
  logic          out_valid_r, out_valid_nxt;
  logic [127:0]  out_res_r, out_res_nxt;

  logic [2:0]    nk_m1;
  logic [3:0]    nr;
  logic [5:0]    total_m1;
  logic          dec_c;
  aesm_kind_t    kind;
  logic          last;
  logic [127:0]  rdata;
  logic          ram_we;
  logic [127:0]  ram_wdata;
  logic [63:0]   kw;
  logic [31:0]   w_new, t_word;
  logic [127:0]  rnd_out, fin_res, fin_chain, cin, chain_eff;
  logic          in_acc;

  assign kind  = aesm_kind_t'(cipher_mode_r[2:1]);
  assign dec_c = cipher_mode_r[0] && (kind == KIND_ECB || kind == KIND_CBC);

  always_comb begin
    case (key_size_r)
      KSIZE_128: begin nk_m1 = 3'd3; nr = 4'd10; total_m1 = 6'd43; end
      KSIZE_192: begin nk_m1 = 3'd5; nr = 4'd12; total_m1 = 6'd51; end
      default:   begin nk_m1 = 3'd7; nr = 4'd14; total_m1 = 6'd59; end
    endcase
  end

  aesm_ram #(.WIDTH(128), .DEPTH(KEY_ROWS)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (i_r[5:2]),
    .wdata (ram_wdata),
    .raddr (ka_r),
    .rdata (rdata)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_result_high = out_res_r[127:64];
  assign out_result_low  = out_res_r[63:0];
  assign last            = (rnd_r == nr);

  // key expansion word
  assign kw = key_word_r[i_r[2:1]];
  always_comb begin
    t_word = win_r[0];
    if (pos_r == 3'd0) begin
      t_word = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rcon_r, 24'h0};
    end else if (nk_m1 == 3'd7 && pos_r == 3'd4) begin
      t_word = sub_word(win_r[0]);
    end
    if (i_r <= {3'b000, nk_m1}) begin
      w_new = i_r[0] ? kw[31:0] : kw[63:32];
    end else begin
      w_new = win_r[nk_m1] ^ t_word;
    end
  end
  assign ram_wdata = {win_r[2], win_r[1], win_r[0], w_new};
  assign ram_we    = (state_r == ST_EXPAND) && (i_r[1:0] == 2'b11);

  // one cipher round
  always_comb begin
    logic [127:0] t;
    if (dec_c) begin
      t = sub_bytes(shift_rows(st_r, 1'b1), 1'b1) ^ rdata;
      rnd_out = last ? t : mix_columns(t, 1'b1);
    end else begin
      t = shift_rows(sub_bytes(st_r, 1'b0), 1'b0);
      rnd_out = (last ? t : mix_columns(t, 1'b0)) ^ rdata;
    end
  end

  // chaining on the cipher output
  always_comb begin
    fin_res   = st_r;
    fin_chain = chain_r;
    case (kind)
      KIND_ECB: begin
        fin_res = st_r;
      end
      KIND_CBC: begin
        if (cipher_mode_r[0]) begin
          fin_res   = st_r ^ chain_r;
          fin_chain = data_r;
        end else begin
          fin_res   = st_r;
          fin_chain = st_r;
        end
      end
      KIND_CFB: begin
        fin_res   = data_r ^ st_r;
        fin_chain = cipher_mode_r[0] ? data_r : (data_r ^ st_r);
      end
      default: begin
        fin_res   = data_r ^ st_r;
        fin_chain = st_r;
      end
    endcase
  end

  assign chain_eff = in_first_block ? {iv_high_r, iv_low_r} : chain_r;

  always_comb begin
    case (kind)
      KIND_ECB: cin = {in_block_high, in_block_low};
      KIND_CBC: cin = cipher_mode_r[0] ? {in_block_high, in_block_low}
                                       : ({in_block_high, in_block_low} ^ chain_eff);
      default:  cin = chain_eff;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    sched_ready_nxt = sched_ready_r;
    chain_nxt       = chain_r;
    data_nxt        = data_r;
    st_nxt          = st_r;
    ka_nxt          = ka_r;
    rnd_nxt         = rnd_r;
    i_nxt           = i_r;
    pos_nxt         = pos_r;
    rcon_nxt        = rcon_r;
    win_nxt         = win_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_res_nxt     = out_res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          data_nxt  = {in_block_high, in_block_low};
          chain_nxt = chain_eff;
          st_nxt    = cin;
          ka_nxt    = dec_c ? nr : '0;
          i_nxt     = '0;
          pos_nxt   = '0;
          rcon_nxt  = 8'h01;
          state_nxt = sched_ready_r ? ST_START : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        win_nxt[0] = w_new;
        for (int k = 1; k < 8; k++) begin
          win_nxt[k] = win_r[k-1];
        end
        if (i_r > {3'b000, nk_m1}) begin
          if (pos_r == nk_m1) begin
            pos_nxt  = '0;
            rcon_nxt = xt(rcon_r);
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
        end
        i_nxt = i_r + 6'd1;
        if (i_r == total_m1) begin
          sched_ready_nxt = 1'b1;
          state_nxt       = ST_START;
        end
      end
      ST_START: begin
        ka_nxt    = dec_c ? ka_r - 1'b1 : ka_r + 1'b1;
        state_nxt = ST_ARK0;
      end
      ST_ARK0: begin
        st_nxt    = st_r ^ rdata;
        ka_nxt    = dec_c ? ka_r - 1'b1 : ka_r + 1'b1;
        rnd_nxt   = 4'd1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        st_nxt = rnd_out;
        if (last) begin
          state_nxt = ST_FIN;
        end else begin
          ka_nxt  = dec_c ? ka_r - 1'b1 : ka_r + 1'b1;
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = fin_res;
          chain_nxt     = fin_chain;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                   cfg_index == REG_KEY2 || cfg_index == REG_KEY3 ||
                   cfg_index == REG_KSIZE)) begin
      sched_ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
      chain_r       <= '0;
      key_word_r    <= '{default: '0};
      iv_high_r     <= '0;
      iv_low_r      <= '0;
      key_size_r    <= '0;
      cipher_mode_r <= '0;
      ka_r          <= '0;
      rnd_r         <= '0;
      i_r           <= '0;
      pos_r         <= '0;
    end else begin
      sched_ready_r <= sched_ready_nxt;
      out_valid_r   <= out_valid_nxt;
      chain_r       <= chain_nxt;
      ka_r          <= ka_nxt;
      rnd_r         <= rnd_nxt;
      i_r           <= i_nxt;
      pos_r         <= pos_nxt;
      if (cfg_we) begin
        case (aesm_reg_t'(cfg_index))
          REG_KEY0:  key_word_r[0] <= cfg_data;
          REG_KEY1:  key_word_r[1] <= cfg_data;
          REG_KEY2:  key_word_r[2] <= cfg_data;
          REG_KEY3:  key_word_r[3] <= cfg_data;
          REG_IV_HI: iv_high_r     <= cfg_data;
          REG_IV_LO: iv_low_r      <= cfg_data;
          REG_KSIZE: key_size_r    <= cfg_data[1:0];
          REG_MODE:  cipher_mode_r <= cfg_data[2:0];
          default:   cipher_mode_r <= cipher_mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    st_r      <= st_nxt;
    rcon_r    <= rcon_nxt;
    win_r     <= win_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

@@ src/aesm_checker.sv @@
// ----------------------------------------------------------------------------
// aesm_checker
// Port-level checks for the AES core, bound to the top level.
// ----------------------------------------------------------------------------
module aesm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result_high,
  input logic [63:0] out_result_low
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !(out_valid && !$past(out_valid)))
    else $error("result appeared one cycle after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_high) &&
    $stable(out_result_low))
    else $error("stalled result changed");

endmodule

bind aes_block_cipher_with_modes_core aesm_checker u_aesm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_high (out_result_high),
  .out_result_low  (out_result_low)
);
